// ===== design/mcr_pkg.sv =====
// shared types and constants of the moravec corner response block
`timescale 1ns / 1ps
package mcr_pkg;

  // frame geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS  = 11;
  localparam int HEIGHT_BITS = 16;
  localparam int ROW_BITS    = HEIGHT_BITS + 1;
  localparam int CFG_BITS    = 16;

  // pixel and window sizes
  localparam int PIX_BITS  = 8;
  localparam int WIN       = 6;
  localparam int MEM_ROWS  = WIN - 1;
  localparam int PATCH     = 3;
  localparam int PATCH_N   = PATCH * PATCH;
  localparam int SHIFTS    = 15;
  localparam int SQ_BITS   = 2 * PIX_BITS;
  localparam int RESP_BITS = 20;

  // operation codes of an input request
  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  // register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 11'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

  typedef logic [PIX_BITS-1:0] pix_t;
  typedef pix_t [WIN-1:0] colvec_t;
  typedef pix_t [MEM_ROWS-1:0] memword_t;
  typedef logic [SQ_BITS-1:0] sq_t;
  typedef logic [RESP_BITS-1:0] resp_t;

  typedef struct packed {
    logic                operation;
    logic [PIX_BITS-1:0] pixel_value;
  } mcr_in_t;

  typedef struct packed {
    logic [RESP_BITS-1:0]   response;
    logic [HEIGHT_BITS-1:0] row_index;
    logic [COL_BITS-1:0]    column_index;
    logic                   frame_end;
  } mcr_out_t;

endpackage

// ===== design/moravec_corner_response_top.sv =====
// moravec corner response: line store, window and shifted difference pipeline
`timescale 1ns / 1ps
// Pixels enter in raster order at one per clock while in_stall is low and each
// produces at most one response, for the pixel one row and one column behind
// it; a response passes the stage 1 to 4 registers and the output register.
// The line store is a 1024 x 40-bit memory holding the five previous rows
// of each column, read and written back once per pixel, which sets the rate of
// one pixel per clock. After the last pixel of a frame, each drain request
// flushes up to two responses and stalls the input while it does so. The
// store needs no clearing after reset. Any register write restarts the frame.
module moravec_corner_response_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  mcr_pkg::mcr_in_t                     in_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output mcr_pkg::mcr_out_t                    out_data,
  input  logic                                 cfg_we,
  input  logic                                 cfg_index,
  input  logic [mcr_pkg::CFG_BITS-1:0]         cfg_wdata
);

  localparam int CB = mcr_pkg::COL_BITS;
  localparam int RB = mcr_pkg::ROW_BITS;
  localparam int HB = mcr_pkg::HEIGHT_BITS;
  localparam int WB = mcr_pkg::WIDTH_BITS;

  // configuration registers
  logic [WB-1:0] width_r;
  logic [HB-1:0] height_r;
  logic [WB-1:0] w_eff;
  logic [HB-1:0] h_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= mcr_pkg::WIDTH_RESET;
      height_r <= mcr_pkg::HEIGHT_RESET;
    end else if (cfg_we) begin
      if (cfg_index == mcr_pkg::REG_WIDTH) width_r <= cfg_wdata[WB-1:0];
      else height_r <= cfg_wdata[HB-1:0];
    end
  end

  // width and height as used
  always_comb begin
    if (width_r == '0) w_eff = WB'(1);
    else if (width_r > WB'(mcr_pkg::MAX_WIDTH)) w_eff = WB'(mcr_pkg::MAX_WIDTH);
    else w_eff = width_r;
    h_eff = (height_r == '0) ? HB'(1) : height_r;
  end

  // handshake and issue control
  logic          out_valid_r;
  logic          adv;
  logic          in_acc;
  logic          done;
  logic          pix_issue;
  logic          drain_start;
  logic          virt_issue;
  logic          issue;
  logic          drain_act_r, drain_act_nxt;
  logic          drain_n_r, drain_n_nxt;
  logic [RB-1:0] row_r, row_nxt;
  logic [CB-1:0] col_r, col_nxt;

  // arrival decode
  logic          a_wrap;
  logic          a_emit;
  logic          a_last;
  logic [RB-1:0] a_oi;
  logic [CB-1:0] a_oj;
  logic [WB-1:0] col_inc;

  assign adv         = !out_valid_r || !out_stall;
  assign in_stall    = !adv || drain_act_r;
  assign in_acc      = in_valid && !in_stall;
  assign done        = row_r >= {1'b0, h_eff};
  assign pix_issue   = in_acc && (in_data.operation == mcr_pkg::OP_PIXEL) && !done;
  assign drain_start = in_acc && (in_data.operation == mcr_pkg::OP_DRAIN) && done;
  assign virt_issue  = drain_act_r && adv;
  assign issue       = pix_issue || virt_issue;

  // which response the arrival at row_r, col_r completes
  always_comb begin
    logic [WB-1:0] wm1;
    wm1     = w_eff - WB'(1);
    a_wrap  = (col_r == '0);
    a_emit  = (row_r >= RB'(2)) || ((row_r == RB'(1)) && !a_wrap);
    a_oi    = a_wrap ? (row_r - RB'(2)) : (row_r - RB'(1));
    a_oj    = a_wrap ? wm1[CB-1:0] : (col_r - CB'(1));
    a_last  = a_wrap && (row_r == ({1'b0, h_eff} + RB'(1)));
    col_inc = {1'b0, col_r} + WB'(1);
  end

  // position counters and drain sequencing
  always_comb begin
    row_nxt       = row_r;
    col_nxt       = col_r;
    drain_act_nxt = drain_act_r;
    drain_n_nxt   = drain_n_r;
    if (issue) begin
      if (a_last) begin
        row_nxt = '0;
        col_nxt = '0;
      end else if (col_inc >= w_eff) begin
        row_nxt = row_r + RB'(1);
        col_nxt = '0;
      end else begin
        col_nxt = col_inc[CB-1:0];
      end
    end
    if (virt_issue) begin
      if (a_last || (a_emit && drain_n_r)) begin
        drain_act_nxt = 1'b0;
        drain_n_nxt   = 1'b0;
      end else begin
        drain_n_nxt = drain_n_r | a_emit;
      end
    end else if (drain_start) begin
      drain_act_nxt = 1'b1;
      drain_n_nxt   = 1'b0;
    end
    if (cfg_we) begin
      row_nxt       = '0;
      col_nxt       = '0;
      drain_act_nxt = 1'b0;
      drain_n_nxt   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r       <= '0;
      col_r       <= '0;
      drain_act_r <= 1'b0;
      drain_n_r   <= 1'b0;
    end else begin
      row_r       <= row_nxt;
      col_r       <= col_nxt;
      drain_act_r <= drain_act_nxt;
      drain_n_r   <= drain_n_nxt;
    end
  end

  // stage 1: line store read, pending write and request info
  mcr_pkg::memword_t line_mem [mcr_pkg::MAX_WIDTH];
  mcr_pkg::memword_t rd_q;
  mcr_pkg::memword_t fwd_word_r;
  mcr_pkg::memword_t rd_word;
  mcr_pkg::memword_t wr_word;
  logic              fwd_r;
  logic              s1_valid_r;
  logic              s1_pix_r;
  logic              s1_emit_r;
  logic              s1_wrap_r;
  logic              s1_last_r;
  mcr_pkg::pix_t     s1_pixel_r;
  logic [RB-1:0]     s1_row_r;
  logic [CB-1:0]     s1_col_r;
  logic [HB-1:0]     s1_oi_r;
  logic [CB-1:0]     s1_oj_r;
  logic              s1_wr;

  assign s1_wr = s1_valid_r && s1_pix_r;

  // read-modify-write of one column entry, forwarding the write just behind
  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_wr) line_mem[s1_col_r] <= wr_word;
      if (issue) rd_q <= line_mem[col_r];
      fwd_r      <= s1_wr && issue && (s1_col_r == col_r);
      fwd_word_r <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && issue) begin
      s1_pix_r   <= pix_issue;
      s1_emit_r  <= a_emit;
      s1_wrap_r  <= a_wrap;
      s1_last_r  <= a_last;
      s1_pixel_r <= in_data.pixel_value;
      s1_row_r   <= row_r;
      s1_col_r   <= col_r;
      s1_oi_r    <= a_oi[HB-1:0];
      s1_oj_r    <= a_oj;
    end
  end

  // column vector with rows clamped to the frame, and the new store entry
  mcr_pkg::colvec_t newv;
  always_comb begin
    mcr_pkg::colvec_t raw;
    logic [2:0]       lowsrc;
    logic [2:0]       hisrc;
    logic [2:0]       src;
    rd_word = fwd_r ? fwd_word_r : rd_q;
    for (int k = 0; k < mcr_pkg::MEM_ROWS; k++) raw[k] = rd_word[k];
    raw[mcr_pkg::WIN-1] = s1_pixel_r;
    for (int k = 0; k < mcr_pkg::MEM_ROWS - 1; k++) wr_word[k] = rd_word[k+1];
    wr_word[mcr_pkg::MEM_ROWS-1] = s1_pixel_r;
    lowsrc = (s1_row_r < RB'(5)) ? (3'd5 - s1_row_r[2:0]) : 3'd0;
    if (s1_row_r >= {1'b0, h_eff}) begin
      hisrc = (s1_row_r == {1'b0, h_eff}) ? 3'd4 : 3'd3;
    end else begin
      hisrc = 3'd5;
    end
    for (int k = 0; k < mcr_pkg::WIN; k++) begin
      src = (3'(k) < lowsrc) ? lowsrc : 3'(k);
      if (src > hisrc) src = hisrc;
      newv[k] = raw[src];
    end
  end

  // window of six columns, clamped to the frame's left and right edges
  mcr_pkg::colvec_t colreg_r [mcr_pkg::WIN];
  mcr_pkg::colvec_t win [mcr_pkg::WIN];
  always_comb begin
    mcr_pkg::colvec_t ext [mcr_pkg::WIN+1];
    logic [2:0]       lowtap;
    logic [2:0]       idx;
    for (int t = 0; t < mcr_pkg::WIN; t++) ext[t] = colreg_r[t];
    ext[mcr_pkg::WIN] = newv;
    if (s1_wrap_r) begin
      lowtap = (w_eff < WB'(6)) ? (3'd6 - w_eff[2:0]) : 3'd0;
    end else begin
      lowtap = (s1_col_r < CB'(5)) ? (3'd5 - s1_col_r[2:0]) : 3'd0;
    end
    for (int m = 0; m < mcr_pkg::WIN; m++) begin
      if (s1_wrap_r) begin
        idx = (3'(m + 1) < lowtap) ? lowtap : 3'(m + 1);
        if (idx > 3'd5) idx = 3'd5;
      end else begin
        idx = ((3'(m) < lowtap) ? lowtap : 3'(m)) + 3'd1;
      end
      win[m] = ext[idx];
    end
  end

  // stage 2: registered window
  mcr_pkg::colvec_t s2_win_r [mcr_pkg::WIN];
  logic             s2_valid_r;
  logic [HB-1:0]    s2_oi_r;
  logic [CB-1:0]    s2_oj_r;
  logic             s2_last_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      if (s1_valid_r) begin
        for (int t = 0; t < mcr_pkg::WIN - 1; t++) colreg_r[t] <= colreg_r[t+1];
        colreg_r[mcr_pkg::WIN-1] <= newv;
      end
      s2_win_r  <= win;
      s2_oi_r   <= s1_oi_r;
      s2_oj_r   <= s1_oj_r;
      s2_last_r <= s1_last_r;
    end
  end

  // stage 3: squared differences of every shift
  mcr_pkg::sq_t  sq_nxt [mcr_pkg::SHIFTS][mcr_pkg::PATCH_N];
  mcr_pkg::sq_t  s3_sq_r [mcr_pkg::SHIFTS][mcr_pkg::PATCH_N];
  logic          s3_valid_r;
  logic [HB-1:0] s3_oi_r;
  logic [CB-1:0] s3_oj_r;
  logic          s3_last_r;

  always_comb begin
    mcr_pkg::pix_t a;
    mcr_pkg::pix_t b;
    mcr_pkg::pix_t ad;
    int            q;
    for (int s = 0; s < mcr_pkg::SHIFTS + 1; s++) begin
      // the zero shift sits at code ten and is skipped
      if (s != 10) begin
        q = (s < 10) ? s : s - 1;
        for (int u = 0; u < mcr_pkg::PATCH; u++) begin
          for (int v = 0; v < mcr_pkg::PATCH; v++) begin
            a  = s2_win_r[v+2][u+2];
            b  = s2_win_r[v + (s & 3)][u + (s >> 2)];
            ad = (a > b) ? (a - b) : (b - a);
            sq_nxt[q][u*mcr_pkg::PATCH+v] = ad * ad;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_sq_r   <= sq_nxt;
      s3_oi_r   <= s2_oi_r;
      s3_oj_r   <= s2_oj_r;
      s3_last_r <= s2_last_r;
    end
  end

  // stage 4: sum per shift
  mcr_pkg::resp_t sum_nxt [mcr_pkg::SHIFTS];
  mcr_pkg::resp_t s4_sum_r [mcr_pkg::SHIFTS];
  logic           s4_valid_r;
  logic [HB-1:0]  s4_oi_r;
  logic [CB-1:0]  s4_oj_r;
  logic           s4_last_r;

  always_comb begin
    for (int q = 0; q < mcr_pkg::SHIFTS; q++) begin
      sum_nxt[q] = '0;
      for (int n = 0; n < mcr_pkg::PATCH_N; n++) begin
        sum_nxt[q] = sum_nxt[q] + mcr_pkg::RESP_BITS'(s3_sq_r[q][n]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s4_sum_r  <= sum_nxt;
      s4_oi_r   <= s3_oi_r;
      s4_oj_r   <= s3_oj_r;
      s4_last_r <= s3_last_r;
    end
  end

  // minimum over the shifts as a four-level tree
  mcr_pkg::resp_t min_nxt;
  always_comb begin
    mcr_pkg::resp_t l1 [8];
    mcr_pkg::resp_t l2 [4];
    mcr_pkg::resp_t l3 [2];
    for (int p = 0; p < 7; p++) begin
      l1[p] = (s4_sum_r[2*p] < s4_sum_r[2*p+1]) ? s4_sum_r[2*p] : s4_sum_r[2*p+1];
    end
    l1[7] = s4_sum_r[mcr_pkg::SHIFTS-1];
    for (int p = 0; p < 4; p++) l2[p] = (l1[2*p] < l1[2*p+1]) ? l1[2*p] : l1[2*p+1];
    for (int p = 0; p < 2; p++) l3[p] = (l2[2*p] < l2[2*p+1]) ? l2[2*p] : l2[2*p+1];
    min_nxt = (l3[0] < l3[1]) ? l3[0] : l3[1];
  end

  // valid flags of the pipeline
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r  <= 1'b0;
      s3_valid_r  <= 1'b0;
      s4_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid_r && s1_emit_r;
      s3_valid_r  <= s2_valid_r;
      s4_valid_r  <= s3_valid_r;
      out_valid_r <= s4_valid_r;
    end
  end

  // output register
  mcr_pkg::mcr_out_t out_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_r.response     <= min_nxt;
      out_r.row_index    <= s4_oi_r;
      out_r.column_index <= s4_oj_r;
      out_r.frame_end    <= s4_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
